[rtl/core/texs_pkg.sv]
// ---------------------------------------------------------------------------
// texs_pkg
// Shared constants, types, texel expansion and coordinate wrap for the bilinear texture sampler.
// ---------------------------------------------------------------------------
package texs_pkg;

    localparam int TEXELS  = 65536;
    localparam int ADDR_W  = $clog2(TEXELS);
    localparam int MAX_DIM = 1024;
    localparam int DIM_W   = 11;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int ROW_W   = POS_W + DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER = 3'd4;

    localparam logic [1:0] FMT_GRAY8  = 2'd0;
    localparam logic [1:0] FMT_RGB24  = 2'd1;
    localparam logic [1:0] FMT_RGBA32 = 2'd2;

    localparam logic [1:0] WRAP_CLAMP  = 2'd0;
    localparam logic [1:0] WRAP_REPEAT = 2'd1;
    localparam logic [1:0] WRAP_MIRROR = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic FILT_NEAREST  = 1'b0;
    localparam logic FILT_BILINEAR = 1'b1;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0][7:0] t_rgba;

    function automatic t_rgba expand(input logic [31:0] texel, input logic [1:0] fmt);
        t_rgba c;
        case (fmt)
            FMT_GRAY8: begin
                c = {8'hFF, texel[7:0], texel[7:0], texel[7:0]};
            end
            FMT_RGB24: begin
                c = {8'hFF, texel[23:16], texel[15:8], texel[7:0]};
            end
            FMT_RGBA32: begin
                c = {texel[31:24], texel[23:16], texel[15:8], texel[7:0]};
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    // wrap a Q8.16 coordinate into [0, 65536]
    function automatic logic [16:0] wrap(input logic [23:0] bits, input logic [1:0] mode);
        logic [16:0] t;
        case (mode)
            WRAP_REPEAT: begin
                t = {1'b0, bits[15:0]};
            end
            WRAP_MIRROR: begin
                t = bits[16] ? (17'h10000 - {1'b0, bits[15:0]}) : {1'b0, bits[15:0]};
            end
            default: begin
                if (bits[23]) begin
                    t = '0;
                end else if (bits > 24'h010000) begin
                    t = 17'h10000;
                end else begin
                    t = bits[16:0];
                end
            end
        endcase
        return t;
    endfunction

endpackage

[rtl/core/tex_req_if.sv]
// ---------------------------------------------------------------------------
// tex_req_if
// Request channel: texel writes and sample requests.
// ---------------------------------------------------------------------------
interface tex_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [15:0]        texel_index;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
    logic [7:0]         in_alpha;
    logic signed [23:0] u_coord;
    logic signed [23:0] v_coord;

    modport source (output valid, cmd, texel_index, in_red, in_green, in_blue, in_alpha,
                    u_coord, v_coord, input ready);
    modport sink   (input valid, cmd, texel_index, in_red, in_green, in_blue, in_alpha,
                    u_coord, v_coord, output ready);
endinterface

[rtl/core/tex_rsp_if.sv]
// ---------------------------------------------------------------------------
// tex_rsp_if
// Response channel: sampled color in 8.8 fixed point.
// ---------------------------------------------------------------------------
interface tex_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

[rtl/core/texture_sampler_bilinear_top.sv]
// ---------------------------------------------------------------------------
// texture_sampler_bilinear_top
// Texel store with nearest or bilinear sampling, six-stage pipeline.
// ---------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  i_req     in         valid/ready    cmd, texel_index, rgba bytes, u/v Q8.16
//  o_rsp     out        valid/ready    out_red/green/blue/alpha (8.8)
//  i_cfg_*   in         write enable   register index, 11-bit data
//
//  One request per cycle while o_rsp back-pressure has not filled the pipeline; sample results exit from stage F.
//  Four replicated texel stores give four reads per cycle; writes land in all
//  four at the read stage, so requests see the store in order.
//  Reset clears valids and config; the texel store is not cleared.
//  Each stage holds while the next is full and stalled; bubbles collapse.
// ---------------------------------------------------------------------------
module texture_sampler_bilinear_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [texs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [texs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tex_req_if.sink                         i_req,
    tex_rsp_if.source                       o_rsp
);
    import texs_pkg::*;

    // configuration
    logic [DIM_W-1:0] r_width, r_height;
    logic [1:0]       r_fmt, r_wrap;
    logic             r_filt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_fmt    <= FMT_RGBA32;
            r_wrap   <= WRAP_CLAMP;
            r_filt   <= FILT_NEAREST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_FORMAT: r_fmt    <= i_cfg_data[1:0];
                REG_WRAP:   r_wrap   <= i_cfg_data[1:0];
                REG_FILTER: r_filt   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [POS_W-1:0] w_last, h_last;
    always_comb begin
        w_eff = (r_width == '0) ? DIM_W'(1) :
                (r_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_width;
        h_eff = (r_height == '0) ? DIM_W'(1) :
                (r_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_height;
        w_last = POS_W'(w_eff - DIM_W'(1));
        h_last = POS_W'(h_eff - DIM_W'(1));
    end

    logic              r_cmd_a, r_cmd_b, r_cmd_c;
    logic [ADDR_W-1:0] r_idx_a, r_idx_b, r_idx_c;
    logic [31:0]       r_tex_a, r_tex_b, r_tex_c;
    logic [16:0]       r_tu_a, r_tv_a;

    // stage valids and enables
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf;
    logic en_a, en_b, en_c, en_d, en_e, en_f;
    assign en_f = !r_vf || o_rsp.ready;
    assign en_e = !r_ve || en_f;
    assign en_d = !r_vd || en_e;
    assign en_c = !r_vc || en_d;
    assign en_b = !r_vb || en_c;
    assign en_a = !r_va || en_b;
    assign i_req.ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0;
            r_vd <= 1'b0; r_ve <= 1'b0; r_vf <= 1'b0;
        end else begin
            if (en_a) r_va <= i_req.valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (en_d) r_vd <= r_vc && (r_cmd_c == CMD_SAMPLE);
            if (en_e) r_ve <= r_vd;
            if (en_f) r_vf <= r_ve;
        end
    end

    // stage A: capture and wrap
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_cmd_a <= i_req.cmd;
            r_idx_a <= i_req.texel_index;
            r_tex_a <= {i_req.in_alpha, i_req.in_blue, i_req.in_green, i_req.in_red};
            r_tu_a  <= wrap(i_req.u_coord, r_wrap);
            r_tv_a  <= wrap(i_req.v_coord, r_wrap);
        end
    end

    // stage B: scale by size
    logic [27:0] r_pu_b, r_pv_b;
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_cmd_b <= r_cmd_a;
            r_idx_b <= r_idx_a;
            r_tex_b <= r_tex_a;
            r_pu_b  <= 28'(r_tu_a * w_eff);
            r_pv_b  <= 28'(r_tv_a * h_eff);
        end
    end

    // stage C: clamp neighbors, row offsets
    logic [11:0]      x_b, y_b;
    logic [12:0]      x1_b, y1_b;
    logic [POS_W-1:0] x0_n, x1_n, y0_n, y1_n;
    always_comb begin
        x_b  = r_pu_b[27:16];
        y_b  = r_pv_b[27:16];
        x1_b = {1'b0, x_b} + 13'd1;
        y1_b = {1'b0, y_b} + 13'd1;
        x0_n = (x_b  > 12'(w_last)) ? w_last : POS_W'(x_b);
        x1_n = (x1_b > 13'(w_last)) ? w_last : POS_W'(x1_b);
        y0_n = (y_b  > 12'(h_last)) ? h_last : POS_W'(y_b);
        y1_n = (y1_b > 13'(h_last)) ? h_last : POS_W'(y1_b);
    end

    logic [POS_W-1:0] r_x0_c, r_x1_c;
    logic [ROW_W-1:0] r_row0_c, r_row1_c;
    logic [15:0]      r_fx_c, r_fy_c;
    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_cmd_c  <= r_cmd_b;
            r_idx_c  <= r_idx_b;
            r_tex_c  <= r_tex_b;
            r_x0_c   <= x0_n;
            r_x1_c   <= x1_n;
            r_row0_c <= ROW_W'(y0_n * w_eff);
            r_row1_c <= ROW_W'(y1_n * w_eff);
            r_fx_c   <= r_pu_b[15:0];
            r_fy_c   <= r_pv_b[15:0];
        end
    end

    // stage D: store access; bank 0 (x0,y0), 1 (x1,y0), 2 (x1,y1), 3 (x0,y1)
    logic [3:0][ROW_W-1:0] addr_c;
    always_comb begin
        addr_c[0] = r_row0_c + ROW_W'(r_x0_c);
        addr_c[1] = r_row0_c + ROW_W'(r_x1_c);
        addr_c[2] = r_row1_c + ROW_W'(r_x1_c);
        addr_c[3] = r_row1_c + ROW_W'(r_x0_c);
    end

    logic        wr_en;
    assign wr_en = en_d && r_vc && (r_cmd_c == CMD_WRITE);

    logic [3:0][31:0] r_rd_d;
    logic [3:0]       r_oob_d;
    logic [15:0]      r_fx_d, r_fy_d;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [31:0] r_mem [TEXELS];
        always_ff @(posedge i_clk) begin
            if (wr_en) r_mem[r_idx_c] <= r_tex_c;
            if (en_d)  r_rd_d[b] <= r_mem[addr_c[b][ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            for (int b = 0; b < 4; b++) begin
                r_oob_d[b] <= |addr_c[b][ROW_W-1:ADDR_W];
            end
            r_fx_d <= r_fx_c;
            r_fy_d <= r_fy_c;
        end
    end

    // stage E: expand and blend horizontally
    t_rgba [3:0] col_d;
    logic [16:0] wx1, wx0;
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            col_d[b] = r_oob_d[b] ? expand(32'd0, r_fmt) : expand(r_rd_d[b], r_fmt);
        end
        wx1 = {1'b0, r_fx_d};
        wx0 = 17'h10000 - wx1;
    end

    logic [3:0][23:0] r_top_e, r_bot_e;
    t_rgba            r_c0_e;
    logic [15:0]      r_fy_e;
    always_ff @(posedge i_clk) begin
        if (en_e) begin
            for (int k = 0; k < 4; k++) begin
                r_top_e[k] <= 24'(col_d[0][k] * wx0 + col_d[1][k] * wx1);
                r_bot_e[k] <= 24'(col_d[3][k] * wx0 + col_d[2][k] * wx1);
            end
            r_c0_e <= col_d[0];
            r_fy_e <= r_fy_d;
        end
    end

    // stage F: blend vertically (or pass the (x0,y0) texel in nearest mode), output register
    logic [16:0] wy1, wy0;
    assign wy1 = {1'b0, r_fy_e};
    assign wy0 = 17'h10000 - wy1;

    logic [3:0][40:0] mix_e;
    logic [3:0][15:0] r_out;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mix_e[k] = 41'(r_top_e[k] * wy0) + 41'(r_bot_e[k] * wy1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            for (int k = 0; k < 4; k++) begin
                r_out[k] <= (r_filt == FILT_BILINEAR) ? mix_e[k][39:24]
                                                      : {r_c0_e[k], 8'h00};
            end
        end
    end

    assign o_rsp.valid     = r_vf;
    assign o_rsp.out_red   = r_out[0];
    assign o_rsp.out_green = r_out[1];
    assign o_rsp.out_blue  = r_out[2];
    assign o_rsp.out_alpha = r_out[3];

    a_accept_to_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_va)
        else $error("accepted request not captured");

    a_write_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_d && r_vc && r_cmd_c == CMD_WRITE) |=> !r_vd)
        else $error("texel write reached result path");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vf |-> (r_out[0] <= 16'd65280 && r_out[1] <= 16'd65280 &&
                  r_out[2] <= 16'd65280 && r_out[3] <= 16'd65280))
        else $error("channel above 8.8 full scale");

    a_nearest_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vf && r_filt == FILT_NEAREST) |-> (r_out[0][7:0] == 8'h00))
        else $error("nearest result carries a fraction");

endmodule
